// ===== rtl/core/wgpe_pkg.sv =====
// shared types, constants and helpers of the weighted graph path engine
// no dependencies; used by every module of the block
`default_nettype none

package wgpe_pkg;

  localparam int NSLOT          = 64;
  localparam int NODE_W         = 7;
  localparam int IDX_W          = 6;
  localparam int CNT_W          = 7;
  localparam int WT_W           = 16;
  localparam int DIST_W         = 32;
  localparam int ADJ_AW         = 2 * IDX_W;
  localparam int DEF_MAX_NODES  = 63;
  localparam int DEF_MAX_DEGREE = 64;

  localparam logic [DIST_W-1:0] INF_DIST = 32'h7FFF_FFFF;

  typedef enum logic [2:0] {
    CMD_ADD_USER      = 3'd0,
    CMD_ADD_EDGE      = 3'd1,
    CMD_REMOVE_EDGE   = 3'd2,
    CMD_HOP_PATH      = 3'd3,
    CMD_WEIGHTED_PATH = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REJECT  = 2'd1,
    ST_NO_PATH = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_SINGLE,
    S_AE_CNTA, S_AE_CNTB, S_AE_SCAN, S_AE_CHK, S_AE_FULL, S_AE_WR2,
    S_RM_START, S_RM_CNT, S_RM_RD, S_RM_CHK,
    S_BFS_SEED, S_BFS_POP, S_BFS_CUR, S_BFS_CNT, S_BFS_NRD, S_BFS_NCHK, S_BFS_NSET,
    S_EM_PUSH, S_EM_PAR, S_EM_RD, S_EM_OUT,
    S_WP_SEED, S_WP_RND, S_WP_SCAN, S_WP_PICK, S_WP_CNT, S_WP_NRD, S_WP_NV, S_WP_NUPD
  } state_t;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic [IDX_W-1:0]  cnt_raddr;
    logic              cnt_we;
    logic [IDX_W-1:0]  cnt_waddr;
    logic [CNT_W-1:0]  cnt_wdata;
    logic [ADJ_AW-1:0] adj_raddr;
    logic              adj_we;
    logic [ADJ_AW-1:0] adj_waddr;
    logic [NODE_W-1:0] adj_wid;
    logic [WT_W-1:0]   adj_wwt;
    logic [IDX_W-1:0]  dist_raddr;
    logic              dist_we;
    logic [IDX_W-1:0]  dist_waddr;
    logic [DIST_W-1:0] dist_wdata;
    logic              flags_clear;
    logic              set_settled;
    logic [IDX_W-1:0]  settled_addr;
    logic [IDX_W-1:0]  par_raddr;
    logic              par_we;
    logic [IDX_W-1:0]  par_waddr;
    logic [IDX_W-1:0]  par_wdata;
    logic [IDX_W-1:0]  q_raddr;
    logic              q_we;
    logic [IDX_W-1:0]  q_waddr;
    logic [IDX_W-1:0]  q_wdata;
    logic [IDX_W-1:0]  stk_raddr;
    logic              stk_we;
    logic [IDX_W-1:0]  stk_waddr;
    logic [IDX_W-1:0]  stk_wdata;
    logic              out_load;
    logic [1:0]        out_status;
    logic [NODE_W-1:0] out_node;
    logic [DIST_W-1:0] out_dist;
    logic              out_last;
  } dp_cmd_t;

  // registered read data and output stage status back to the sequencer
  typedef struct packed {
    logic [CNT_W-1:0]  cnt_rdata;
    logic [NODE_W-1:0] adj_rid;
    logic [WT_W-1:0]   adj_rwt;
    logic [DIST_W-1:0] dist_rdata;
    logic              settled_rdata;
    logic [IDX_W-1:0]  par_rdata;
    logic [IDX_W-1:0]  q_rdata;
    logic [IDX_W-1:0]  stk_rdata;
    logic              out_busy;
  } dp_sts_t;

  function automatic logic node_exists(input logic [NODE_W-1:0] id,
                                       input logic [NODE_W-1:0] next_id);
    return (id != '0) && (id < next_id);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/wgpe_datapath.sv =====
// datapath: adjacency, count, distance, parent, queue and path stack memories
// plus the result register; depends on wgpe_pkg
`default_nettype none

module wgpe_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire wgpe_pkg::dp_cmd_t  dcmd,
  output wgpe_pkg::dp_sts_t       dsts,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic [wgpe_pkg::NODE_W-1:0] out_node,
  output logic [wgpe_pkg::DIST_W-1:0] out_dist,
  output logic                    out_last
);

  logic [wgpe_pkg::CNT_W-1:0]  cnt_mem  [wgpe_pkg::NSLOT];
  logic [wgpe_pkg::NSLOT-1:0]  cnt_vld;
  logic [wgpe_pkg::CNT_W-1:0]  cnt_rd;
  logic                        cnt_rv;

  logic [wgpe_pkg::NODE_W+wgpe_pkg::WT_W-1:0] adj_mem [wgpe_pkg::NSLOT*wgpe_pkg::NSLOT];
  logic [wgpe_pkg::NODE_W+wgpe_pkg::WT_W-1:0] adj_rd;

  logic [wgpe_pkg::DIST_W-1:0] dist_mem [wgpe_pkg::NSLOT];
  logic [wgpe_pkg::NSLOT-1:0]  dist_vld;
  logic [wgpe_pkg::NSLOT-1:0]  settled;
  logic [wgpe_pkg::DIST_W-1:0] dist_rd;
  logic                        dist_rv;
  logic                        settled_rd;

  logic [wgpe_pkg::IDX_W-1:0]  par_mem [wgpe_pkg::NSLOT];
  logic [wgpe_pkg::IDX_W-1:0]  q_mem   [wgpe_pkg::NSLOT];
  logic [wgpe_pkg::IDX_W-1:0]  stk_mem [wgpe_pkg::NSLOT];
  logic [wgpe_pkg::IDX_W-1:0]  par_rd, q_rd, stk_rd;

  // memories, no reset
  always_ff @(posedge clk) begin
    if (dcmd.cnt_we) begin
      cnt_mem[dcmd.cnt_waddr] <= dcmd.cnt_wdata;
    end
    if (dcmd.adj_we) begin
      adj_mem[dcmd.adj_waddr] <= {dcmd.adj_wwt, dcmd.adj_wid};
    end
    if (dcmd.dist_we) begin
      dist_mem[dcmd.dist_waddr] <= dcmd.dist_wdata;
    end
    if (dcmd.par_we) begin
      par_mem[dcmd.par_waddr] <= dcmd.par_wdata;
    end
    if (dcmd.q_we) begin
      q_mem[dcmd.q_waddr] <= dcmd.q_wdata;
    end
    if (dcmd.stk_we) begin
      stk_mem[dcmd.stk_waddr] <= dcmd.stk_wdata;
    end
    cnt_rd     <= cnt_mem[dcmd.cnt_raddr];
    cnt_rv     <= cnt_vld[dcmd.cnt_raddr];
    adj_rd     <= adj_mem[dcmd.adj_raddr];
    dist_rd    <= dist_mem[dcmd.dist_raddr];
    dist_rv    <= dist_vld[dcmd.dist_raddr];
    settled_rd <= settled[dcmd.dist_raddr];
    par_rd     <= par_mem[dcmd.par_raddr];
    q_rd       <= q_mem[dcmd.q_raddr];
    stk_rd     <= stk_mem[dcmd.stk_raddr];
  end

  // per entry flags
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld  <= '0;
      dist_vld <= '0;
      settled  <= '0;
    end else begin
      if (dcmd.cnt_we) begin
        cnt_vld[dcmd.cnt_waddr] <= 1'b1;
      end
      if (dcmd.flags_clear) begin
        dist_vld <= '0;
        settled  <= '0;
      end else begin
        if (dcmd.dist_we) begin
          dist_vld[dcmd.dist_waddr] <= 1'b1;
        end
        if (dcmd.set_settled) begin
          settled[dcmd.settled_addr] <= 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dcmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dcmd.out_load) begin
      out_status <= dcmd.out_status;
      out_node   <= dcmd.out_node;
      out_dist   <= dcmd.out_dist;
      out_last   <= dcmd.out_last;
    end
  end

  always_comb begin
    dsts.cnt_rdata     = cnt_rv ? cnt_rd : '0;
    dsts.adj_rid       = adj_rd[wgpe_pkg::NODE_W-1:0];
    dsts.adj_rwt       = adj_rd[wgpe_pkg::NODE_W+wgpe_pkg::WT_W-1:wgpe_pkg::NODE_W];
    dsts.dist_rdata    = dist_rv ? dist_rd : wgpe_pkg::INF_DIST;
    dsts.settled_rdata = settled_rd;
    dsts.par_rdata     = par_rd;
    dsts.q_rdata       = q_rd;
    dsts.stk_rdata     = stk_rd;
    dsts.out_busy      = out_valid && !out_ready;
  end

endmodule

`default_nettype wire

// ===== rtl/core/wgpe_ctrl.sv =====
// sequencer: command decode, edge list edits, breadth-first and dijkstra searches,
// path walk-back and emission; depends on wgpe_pkg
`default_nettype none

module wgpe_ctrl #(
  parameter int MAX_NODES  = wgpe_pkg::DEF_MAX_NODES,
  parameter int MAX_DEGREE = wgpe_pkg::DEF_MAX_DEGREE
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [2:0]                  in_cmd,
  input  wire logic [wgpe_pkg::NODE_W-1:0] in_a,
  input  wire logic [wgpe_pkg::NODE_W-1:0] in_b,
  input  wire logic [wgpe_pkg::WT_W-1:0]   in_w,
  output wgpe_pkg::dp_cmd_t                dcmd,
  input  wire wgpe_pkg::dp_sts_t           dsts
);

  localparam logic [wgpe_pkg::CNT_W-1:0]  MaxDeg  = wgpe_pkg::CNT_W'(MAX_DEGREE);
  localparam logic [wgpe_pkg::NODE_W-1:0] MaxNode = wgpe_pkg::NODE_W'(MAX_NODES);

  wgpe_pkg::state_t state, state_next;

  logic [2:0]                  op, op_next;
  logic [wgpe_pkg::NODE_W-1:0] na, na_next, nb, nb_next;
  logic [wgpe_pkg::WT_W-1:0]   wt, wt_next;
  logic [wgpe_pkg::NODE_W-1:0] next_id, next_id_next;
  logic [wgpe_pkg::CNT_W-1:0]  i, i_next, k, k_next, cnt_x, cnt_x_next, cnt_y, cnt_y_next;
  logic                        sel, sel_next;
  logic [wgpe_pkg::CNT_W-1:0]  head, head_next, tail, tail_next;
  logic [wgpe_pkg::IDX_W-1:0]  cur, cur_next, f, f_next, node, node_next;
  logic [wgpe_pkg::IDX_W-1:0]  pend_id, pend_id_next;
  logic                        pend, pend_next, found, found_next;
  logic [wgpe_pkg::DIST_W-1:0] m, m_next, nd, nd_next, ed, ed_next;
  logic [wgpe_pkg::NODE_W-1:0] rnd, rnd_next, sid, sid_next;
  logic [wgpe_pkg::CNT_W-1:0]  n, n_next;
  logic [1:0]                  rs_status, rs_status_next;
  logic [wgpe_pkg::NODE_W-1:0] rs_node, rs_node_next;
  logic [wgpe_pkg::NODE_W-1:0] side_x, side_y;

  assign in_ready = (state == wgpe_pkg::S_IDLE);
  assign side_x   = sel ? nb : na;
  assign side_y   = sel ? na : nb;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= wgpe_pkg::S_IDLE;
      next_id <= wgpe_pkg::NODE_W'(1);
    end else begin
      state   <= state_next;
      next_id <= next_id_next;
    end
  end

  always_ff @(posedge clk) begin
    op <= op_next;   na <= na_next;     nb <= nb_next;   wt <= wt_next;
    i <= i_next;     k <= k_next;       cnt_x <= cnt_x_next; cnt_y <= cnt_y_next;
    sel <= sel_next; head <= head_next; tail <= tail_next;
    cur <= cur_next; f <= f_next;       node <= node_next;
    pend <= pend_next; pend_id <= pend_id_next; found <= found_next;
    m <= m_next;     nd <= nd_next;     ed <= ed_next;
    rnd <= rnd_next; sid <= sid_next;   n <= n_next;
    rs_status <= rs_status_next; rs_node <= rs_node_next;
  end

  always_comb begin
    state_next = state;
    op_next = op;   na_next = na;     nb_next = nb;   wt_next = wt;
    next_id_next = next_id;
    i_next = i;     k_next = k;       cnt_x_next = cnt_x; cnt_y_next = cnt_y;
    sel_next = sel; head_next = head; tail_next = tail;
    cur_next = cur; f_next = f;       node_next = node;
    pend_next = pend; pend_id_next = pend_id; found_next = found;
    m_next = m;     nd_next = nd;     ed_next = ed;
    rnd_next = rnd; sid_next = sid;   n_next = n;
    rs_status_next = rs_status; rs_node_next = rs_node;
    dcmd = '0;
    dcmd.stk_raddr = wgpe_pkg::IDX_W'(n - wgpe_pkg::CNT_W'(1) - k);

    unique case (state)
      wgpe_pkg::S_IDLE: begin
        if (in_valid) begin
          op_next = in_cmd; na_next = in_a; nb_next = in_b; wt_next = in_w;
          state_next = wgpe_pkg::S_DISPATCH;
        end
      end

      wgpe_pkg::S_DISPATCH: begin
        rs_status_next = wgpe_pkg::ST_REJECT;
        rs_node_next   = '0;
        state_next     = wgpe_pkg::S_SINGLE;
        case (op)
          wgpe_pkg::CMD_ADD_USER: begin
            if (next_id <= MaxNode) begin
              rs_status_next = wgpe_pkg::ST_OK;
              rs_node_next   = next_id;
              next_id_next   = next_id + wgpe_pkg::NODE_W'(1);
            end
          end
          wgpe_pkg::CMD_ADD_EDGE: begin
            if (na != nb && wgpe_pkg::node_exists(na, next_id)
                && wgpe_pkg::node_exists(nb, next_id)) begin
              dcmd.cnt_raddr = na[wgpe_pkg::IDX_W-1:0];
              state_next     = wgpe_pkg::S_AE_CNTA;
            end
          end
          wgpe_pkg::CMD_REMOVE_EDGE: begin
            sel_next   = 1'b0;
            state_next = wgpe_pkg::S_RM_START;
          end
          wgpe_pkg::CMD_HOP_PATH, wgpe_pkg::CMD_WEIGHTED_PATH: begin
            if (na == nb) begin
              rs_status_next = wgpe_pkg::ST_OK;
              rs_node_next   = na;
            end else if (op == wgpe_pkg::CMD_HOP_PATH) begin
              if (wgpe_pkg::node_exists(na, next_id)) begin
                dcmd.flags_clear = 1'b1;
                state_next       = wgpe_pkg::S_BFS_SEED;
              end else begin
                rs_status_next = wgpe_pkg::ST_NO_PATH;
              end
            end else begin
              dcmd.flags_clear = 1'b1;
              state_next       = wgpe_pkg::S_WP_SEED;
            end
          end
          default: begin
          end
        endcase
      end

      wgpe_pkg::S_SINGLE: begin
        if (!dsts.out_busy) begin
          dcmd.out_load   = 1'b1;
          dcmd.out_status = rs_status;
          dcmd.out_node   = rs_node;
          dcmd.out_last   = 1'b1;
          state_next      = wgpe_pkg::S_IDLE;
        end
      end

      // add edge
      wgpe_pkg::S_AE_CNTA: begin
        cnt_x_next     = dsts.cnt_rdata;
        dcmd.cnt_raddr = nb[wgpe_pkg::IDX_W-1:0];
        state_next     = wgpe_pkg::S_AE_CNTB;
      end
      wgpe_pkg::S_AE_CNTB: begin
        cnt_y_next = dsts.cnt_rdata;
        i_next     = '0;
        state_next = wgpe_pkg::S_AE_SCAN;
      end
      wgpe_pkg::S_AE_SCAN: begin
        if (i < cnt_x) begin
          dcmd.adj_raddr = {na[wgpe_pkg::IDX_W-1:0], i[wgpe_pkg::IDX_W-1:0]};
          state_next     = wgpe_pkg::S_AE_CHK;
        end else begin
          state_next = wgpe_pkg::S_AE_FULL;
        end
      end
      wgpe_pkg::S_AE_CHK: begin
        if (dsts.adj_rid == nb) begin
          rs_status_next = wgpe_pkg::ST_REJECT;
          rs_node_next   = '0;
          state_next     = wgpe_pkg::S_SINGLE;
        end else begin
          i_next     = i + wgpe_pkg::CNT_W'(1);
          state_next = wgpe_pkg::S_AE_SCAN;
        end
      end
      wgpe_pkg::S_AE_FULL: begin
        if (cnt_x >= MaxDeg || cnt_y >= MaxDeg) begin
          rs_status_next = wgpe_pkg::ST_REJECT;
          rs_node_next   = '0;
          state_next     = wgpe_pkg::S_SINGLE;
        end else begin
          dcmd.adj_we    = 1'b1;
          dcmd.adj_waddr = {na[wgpe_pkg::IDX_W-1:0], cnt_x[wgpe_pkg::IDX_W-1:0]};
          dcmd.adj_wid   = nb;
          dcmd.adj_wwt   = wt;
          dcmd.cnt_we    = 1'b1;
          dcmd.cnt_waddr = na[wgpe_pkg::IDX_W-1:0];
          dcmd.cnt_wdata = cnt_x + wgpe_pkg::CNT_W'(1);
          state_next     = wgpe_pkg::S_AE_WR2;
        end
      end
      wgpe_pkg::S_AE_WR2: begin
        dcmd.adj_we    = 1'b1;
        dcmd.adj_waddr = {nb[wgpe_pkg::IDX_W-1:0], cnt_y[wgpe_pkg::IDX_W-1:0]};
        dcmd.adj_wid   = na;
        dcmd.adj_wwt   = wt;
        dcmd.cnt_we    = 1'b1;
        dcmd.cnt_waddr = nb[wgpe_pkg::IDX_W-1:0];
        dcmd.cnt_wdata = cnt_y + wgpe_pkg::CNT_W'(1);
        rs_status_next = wgpe_pkg::ST_OK;
        rs_node_next   = '0;
        state_next     = wgpe_pkg::S_SINGLE;
      end

      // remove edge, one side then the other, compacting in place
      wgpe_pkg::S_RM_START: begin
        if (wgpe_pkg::node_exists(side_x, next_id)) begin
          cur_next       = side_x[wgpe_pkg::IDX_W-1:0];
          dcmd.cnt_raddr = side_x[wgpe_pkg::IDX_W-1:0];
          state_next     = wgpe_pkg::S_RM_CNT;
        end else if (sel) begin
          rs_status_next = wgpe_pkg::ST_OK;
          rs_node_next   = '0;
          state_next     = wgpe_pkg::S_SINGLE;
        end else begin
          sel_next = 1'b1;
        end
      end
      wgpe_pkg::S_RM_CNT: begin
        cnt_x_next = dsts.cnt_rdata;
        i_next     = '0;
        k_next     = '0;
        state_next = wgpe_pkg::S_RM_RD;
      end
      wgpe_pkg::S_RM_RD: begin
        if (i < cnt_x) begin
          dcmd.adj_raddr = {cur, i[wgpe_pkg::IDX_W-1:0]};
          state_next     = wgpe_pkg::S_RM_CHK;
        end else begin
          dcmd.cnt_we    = 1'b1;
          dcmd.cnt_waddr = cur;
          dcmd.cnt_wdata = k;
          if (sel) begin
            rs_status_next = wgpe_pkg::ST_OK;
            rs_node_next   = '0;
            state_next     = wgpe_pkg::S_SINGLE;
          end else begin
            sel_next   = 1'b1;
            state_next = wgpe_pkg::S_RM_START;
          end
        end
      end
      wgpe_pkg::S_RM_CHK: begin
        if (dsts.adj_rid != side_y) begin
          dcmd.adj_we    = 1'b1;
          dcmd.adj_waddr = {cur, k[wgpe_pkg::IDX_W-1:0]};
          dcmd.adj_wid   = dsts.adj_rid;
          dcmd.adj_wwt   = dsts.adj_rwt;
          k_next         = k + wgpe_pkg::CNT_W'(1);
        end
        i_next     = i + wgpe_pkg::CNT_W'(1);
        state_next = wgpe_pkg::S_RM_RD;
      end

      // breadth-first search
      wgpe_pkg::S_BFS_SEED: begin
        dcmd.set_settled  = 1'b1;
        dcmd.settled_addr = na[wgpe_pkg::IDX_W-1:0];
        dcmd.q_we         = 1'b1;
        dcmd.q_waddr      = '0;
        dcmd.q_wdata      = na[wgpe_pkg::IDX_W-1:0];
        tail_next         = wgpe_pkg::CNT_W'(1);
        head_next         = '0;
        state_next        = wgpe_pkg::S_BFS_POP;
      end
      wgpe_pkg::S_BFS_POP: begin
        if (head < tail) begin
          dcmd.q_raddr = head[wgpe_pkg::IDX_W-1:0];
          head_next    = head + wgpe_pkg::CNT_W'(1);
          state_next   = wgpe_pkg::S_BFS_CUR;
        end else begin
          rs_status_next = wgpe_pkg::ST_NO_PATH;
          rs_node_next   = '0;
          state_next     = wgpe_pkg::S_SINGLE;
        end
      end
      wgpe_pkg::S_BFS_CUR: begin
        cur_next       = dsts.q_rdata;
        dcmd.cnt_raddr = dsts.q_rdata;
        state_next     = wgpe_pkg::S_BFS_CNT;
      end
      wgpe_pkg::S_BFS_CNT: begin
        cnt_x_next = dsts.cnt_rdata;
        i_next     = '0;
        state_next = wgpe_pkg::S_BFS_NRD;
      end
      wgpe_pkg::S_BFS_NRD: begin
        if (i < cnt_x) begin
          dcmd.adj_raddr = {cur, i[wgpe_pkg::IDX_W-1:0]};
          state_next     = wgpe_pkg::S_BFS_NCHK;
        end else begin
          state_next = wgpe_pkg::S_BFS_POP;
        end
      end
      wgpe_pkg::S_BFS_NCHK: begin
        // target is tested before the visited check
        if ({1'b0, dsts.adj_rid[wgpe_pkg::IDX_W-1:0]} == nb) begin
          dcmd.par_we    = 1'b1;
          dcmd.par_waddr = dsts.adj_rid[wgpe_pkg::IDX_W-1:0];
          dcmd.par_wdata = cur;
          node_next      = nb[wgpe_pkg::IDX_W-1:0];
          n_next         = '0;
          state_next     = wgpe_pkg::S_EM_PUSH;
        end else begin
          f_next          = dsts.adj_rid[wgpe_pkg::IDX_W-1:0];
          dcmd.dist_raddr = dsts.adj_rid[wgpe_pkg::IDX_W-1:0];
          state_next      = wgpe_pkg::S_BFS_NSET;
        end
      end
      wgpe_pkg::S_BFS_NSET: begin
        if (!dsts.settled_rdata && !tail[wgpe_pkg::CNT_W-1]) begin
          dcmd.set_settled  = 1'b1;
          dcmd.settled_addr = f;
          dcmd.par_we       = 1'b1;
          dcmd.par_waddr    = f;
          dcmd.par_wdata    = cur;
          dcmd.q_we         = 1'b1;
          dcmd.q_waddr      = tail[wgpe_pkg::IDX_W-1:0];
          dcmd.q_wdata      = f;
          tail_next         = tail + wgpe_pkg::CNT_W'(1);
        end
        i_next     = i + wgpe_pkg::CNT_W'(1);
        state_next = wgpe_pkg::S_BFS_NRD;
      end

      // walk parents from target to start onto the stack, then pop forward
      wgpe_pkg::S_EM_PUSH: begin
        dcmd.stk_we    = 1'b1;
        dcmd.stk_waddr = n[wgpe_pkg::IDX_W-1:0];
        dcmd.stk_wdata = node;
        n_next         = n + wgpe_pkg::CNT_W'(1);
        if ({1'b0, node} == na || n == wgpe_pkg::CNT_W'(wgpe_pkg::NSLOT - 1)) begin
          k_next = '0;
          if (op == wgpe_pkg::CMD_HOP_PATH) begin
            ed_next = wgpe_pkg::DIST_W'(n);
          end
          state_next = wgpe_pkg::S_EM_RD;
        end else begin
          dcmd.par_raddr = node;
          state_next     = wgpe_pkg::S_EM_PAR;
        end
      end
      wgpe_pkg::S_EM_PAR: begin
        node_next  = dsts.par_rdata;
        state_next = wgpe_pkg::S_EM_PUSH;
      end
      wgpe_pkg::S_EM_RD: begin
        state_next = wgpe_pkg::S_EM_OUT;
      end
      wgpe_pkg::S_EM_OUT: begin
        if (!dsts.out_busy) begin
          dcmd.out_load   = 1'b1;
          dcmd.out_status = wgpe_pkg::ST_OK;
          dcmd.out_node   = {1'b0, dsts.stk_rdata};
          dcmd.out_dist   = ed;
          dcmd.out_last   = (k == n - wgpe_pkg::CNT_W'(1));
          if (k == n - wgpe_pkg::CNT_W'(1)) begin
            state_next = wgpe_pkg::S_IDLE;
          end else begin
            k_next     = k + wgpe_pkg::CNT_W'(1);
            state_next = wgpe_pkg::S_EM_RD;
          end
        end
      end

      // dijkstra
      wgpe_pkg::S_WP_SEED: begin
        if (wgpe_pkg::node_exists(na, next_id)) begin
          dcmd.dist_we    = 1'b1;
          dcmd.dist_waddr = na[wgpe_pkg::IDX_W-1:0];
          dcmd.dist_wdata = '0;
        end
        rnd_next   = '0;
        state_next = wgpe_pkg::S_WP_RND;
      end
      wgpe_pkg::S_WP_RND: begin
        if (rnd < next_id - wgpe_pkg::NODE_W'(1)) begin
          sid_next   = wgpe_pkg::NODE_W'(1);
          m_next     = wgpe_pkg::INF_DIST;
          found_next = 1'b0;
          pend_next  = 1'b0;
          state_next = wgpe_pkg::S_WP_SCAN;
        end else begin
          rs_status_next = wgpe_pkg::ST_NO_PATH;
          rs_node_next   = '0;
          state_next     = wgpe_pkg::S_SINGLE;
        end
      end
      wgpe_pkg::S_WP_SCAN: begin
        // one id read per cycle, compared in the next cycle; ties go to the higher id
        if (pend && !dsts.settled_rdata && dsts.dist_rdata <= m) begin
          m_next     = dsts.dist_rdata;
          cur_next   = pend_id;
          found_next = 1'b1;
        end
        if (sid < next_id) begin
          dcmd.dist_raddr = sid[wgpe_pkg::IDX_W-1:0];
          pend_next       = 1'b1;
          pend_id_next    = sid[wgpe_pkg::IDX_W-1:0];
          sid_next        = sid + wgpe_pkg::NODE_W'(1);
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            state_next = wgpe_pkg::S_WP_PICK;
          end
        end
      end
      wgpe_pkg::S_WP_PICK: begin
        if (!found || m == wgpe_pkg::INF_DIST) begin
          rs_status_next = wgpe_pkg::ST_NO_PATH;
          rs_node_next   = '0;
          state_next     = wgpe_pkg::S_SINGLE;
        end else if ({1'b0, cur} == nb) begin
          ed_next    = m;
          node_next  = cur;
          n_next     = '0;
          state_next = wgpe_pkg::S_EM_PUSH;
        end else begin
          dcmd.set_settled  = 1'b1;
          dcmd.settled_addr = cur;
          dcmd.cnt_raddr    = cur;
          state_next        = wgpe_pkg::S_WP_CNT;
        end
      end
      wgpe_pkg::S_WP_CNT: begin
        cnt_x_next = dsts.cnt_rdata;
        i_next     = '0;
        state_next = wgpe_pkg::S_WP_NRD;
      end
      wgpe_pkg::S_WP_NRD: begin
        if (i < cnt_x) begin
          dcmd.adj_raddr = {cur, i[wgpe_pkg::IDX_W-1:0]};
          state_next     = wgpe_pkg::S_WP_NV;
        end else begin
          rnd_next   = rnd + wgpe_pkg::NODE_W'(1);
          state_next = wgpe_pkg::S_WP_RND;
        end
      end
      wgpe_pkg::S_WP_NV: begin
        f_next          = dsts.adj_rid[wgpe_pkg::IDX_W-1:0];
        nd_next         = m + wgpe_pkg::DIST_W'(dsts.adj_rwt);
        dcmd.dist_raddr = dsts.adj_rid[wgpe_pkg::IDX_W-1:0];
        state_next      = wgpe_pkg::S_WP_NUPD;
      end
      wgpe_pkg::S_WP_NUPD: begin
        if (!dsts.settled_rdata && nd < dsts.dist_rdata) begin
          dcmd.dist_we    = 1'b1;
          dcmd.dist_waddr = f;
          dcmd.dist_wdata = nd;
          dcmd.par_we     = 1'b1;
          dcmd.par_waddr  = f;
          dcmd.par_wdata  = cur;
        end
        i_next     = i + wgpe_pkg::CNT_W'(1);
        state_next = wgpe_pkg::S_WP_NRD;
      end

      default: begin
        state_next = wgpe_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/weighted_graph_path_engine.sv =====
// top level of the weighted graph path engine: stream ports, sequencer and datapath
// depends on wgpe_pkg, wgpe_ctrl and wgpe_datapath
//
// usage
//   one command word enters on the s_axis side; it gives one or more result words on
//   the m_axis side, m_axis_tlast high on the final word of the command
//   add_user / add_edge / remove_edge and unused codes give a single word; a path
//   command gives one word per path node, start first, or a single no-path word
//   commands are taken one at a time: s_axis_tready is high only while the sequencer
//   waits for a command, also while the previous final word still sits in the output
// work per command (memory reads are registered)
//   add_user: no memory access; add_edge: a scan of the list of node_a, then both writes
//   remove_edge: a read and compacting rewrite of the lists of node_a and node_b
//   hop_path: per queued node a count read, then a read and check of each list entry
//   weighted_path: per settled node a scan of all ids (one distance read a cycle)
//   plus a read and update of each of its list entries
//   path output: the parent walk pushes each node onto a stack, then it is read out start first
// reset clears the id counter, all neighbour counts and the output register at once;
// no clearing pass; a stalled receiver holds the output word and the sequencer waits
`default_nettype none

module weighted_graph_path_engine #(
  parameter int MAX_NODES  = wgpe_pkg::DEF_MAX_NODES,
  parameter int MAX_DEGREE = wgpe_pkg::DEF_MAX_DEGREE
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // node_a[6:0], node_b[13:7], edge_weight[29:14]
  input  wire logic [2:0]  s_axis_tuser,  // cmd[2:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // node_id[6:0], path_distance[38:7]
  output logic [1:0]       m_axis_tuser,  // status[1:0]
  output logic             m_axis_tlast
);

  wgpe_pkg::dp_cmd_t dcmd;
  wgpe_pkg::dp_sts_t dsts;

  logic [1:0]                  out_status;
  logic [wgpe_pkg::NODE_W-1:0] out_node;
  logic [wgpe_pkg::DIST_W-1:0] out_dist;

  // sequencer
  wgpe_ctrl #(
    .MAX_NODES  (MAX_NODES),
    .MAX_DEGREE (MAX_DEGREE)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_cmd   (s_axis_tuser),
    .in_a     (s_axis_tdata[6:0]),
    .in_b     (s_axis_tdata[13:7]),
    .in_w     (s_axis_tdata[29:14]),
    .dcmd     (dcmd),
    .dsts     (dsts)
  );

  // memories and output word register
  wgpe_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .dcmd       (dcmd),
    .dsts       (dsts),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_status (out_status),
    .out_node   (out_node),
    .out_dist   (out_dist),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_dist, out_node};
  assign m_axis_tuser = out_status;

`ifndef SYNTHESIS
  // no command word is accepted in the cycle after an accepted one
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("command accepted while the previous one is still in work");

  // no-path and reject words always close their command
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == wgpe_pkg::ST_NO_PATH
                       || m_axis_tuser == wgpe_pkg::ST_REJECT)) |-> m_axis_tlast)
    else $error("single result word without tlast");

  // no-path words carry no node and no distance
  a_nopath_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == wgpe_pkg::ST_NO_PATH) |-> (m_axis_tdata == '0))
    else $error("no-path word with node or distance set");
`endif

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// testbench of the weighted graph path engine: command stream in, result stream checked
// depends on wgpe_pkg and weighted_graph_path_engine
`default_nettype none

// one result word as the block gives it
typedef struct {
  logic [1:0]  status;
  logic [6:0]  node_id;
  logic [31:0] path_distance;
  logic        last;
} path_word_t;

class path_scoreboard;
  localparam int NS = 64;
  localparam int MAXN = 63;
  localparam int MAXD = 64;
  localparam logic [31:0] UNREACHED = 32'h7FFF_FFFF;

  // graph copy
  int unsigned next_id;
  int unsigned degree [NS];
  int unsigned nbr [NS][NS];
  int unsigned nwt [NS][NS];
  // search scratch
  int unsigned best_d [NS];
  int unsigned parent [NS];
  bit          seen [NS];
  int unsigned fifo [NS];

  path_word_t pending[$];
  int mismatches;

  function new();
    next_id = 1;
    foreach (degree[i]) degree[i] = 0;
    mismatches = 0;
  endfunction

  function bit known(int unsigned id);
    return id >= 1 && id < next_id && id < NS;
  endfunction

  function void push(logic [1:0] st, int unsigned node, int unsigned d, bit lst);
    path_word_t w;
    w.status = st;
    w.node_id = node[6:0];
    w.path_distance = d;
    w.last = lst;
    pending.insert(pending.size(), w);
  endfunction

  function bit linked(int unsigned a, int unsigned b);
    for (int i = 0; i < degree[a]; i++)
      if (nbr[a][i] == b) return 1;
    return 0;
  endfunction

  function void unlink(int unsigned a, int unsigned b);
    int unsigned k;
    k = 0;
    for (int i = 0; i < degree[a]; i++)
      if (nbr[a][i] != b) begin
        nbr[a][k] = nbr[a][i];
        nwt[a][k] = nwt[a][i];
        k++;
      end
    degree[a] = k;
  endfunction

  // walk parents back from the target, emit start first
  function void trace(int unsigned s, int unsigned t, bit hops, int unsigned d);
    int unsigned rev [NS];
    int n;
    int unsigned node;
    n = 0;
    node = t;
    while (n < NS) begin
      rev[n++] = node;
      if (node == s) break;
      node = parent[node % NS];
    end
    if (hops) d = n - 1;
    for (int k = 0; k < n; k++)
      push(wgpe_pkg::ST_OK, rev[n - 1 - k], d, k == n - 1);
  endfunction

  // breadth-first, target tested before the visited check
  function void hop_search(int unsigned s, int unsigned t);
    int unsigned head, tail, cur, f;
    if (!known(s)) begin
      push(wgpe_pkg::ST_NO_PATH, 0, 0, 1);
      return;
    end
    foreach (seen[i]) seen[i] = 0;
    head = 0;
    tail = 0;
    fifo[tail++] = s;
    seen[s] = 1;
    while (head < tail && head < NS) begin
      cur = fifo[head++] % NS;
      for (int i = 0; i < degree[cur]; i++) begin
        f = nbr[cur][i] % NS;
        if (f == t) begin
          parent[f] = cur;
          trace(s, t, 1, 0);
          return;
        end
        if (!seen[f] && tail < NS) begin
          seen[f] = 1;
          parent[f] = cur;
          fifo[tail++] = f;
        end
      end
    end
    push(wgpe_pkg::ST_NO_PATH, 0, 0, 1);
  endfunction

  // dijkstra, ties go to the highest unsettled id
  function void weight_search(int unsigned s, int unsigned t);
    int unsigned u, m, v, nd;
    bit found;
    for (int i = 0; i < NS; i++) begin
      best_d[i] = UNREACHED;
      seen[i] = 0;
      parent[i] = 0;
    end
    if (known(s)) best_d[s] = 0;
    for (int r = 0; r < int'(next_id) - 1; r++) begin
      u = 0;
      m = UNREACHED;
      found = 0;
      for (int id = 1; id < next_id && id < NS; id++)
        if (!seen[id] && best_d[id] <= m) begin
          m = best_d[id];
          u = id;
          found = 1;
        end
      if (!found || m == UNREACHED) break;
      if (u == t) begin
        trace(s, t, 0, m);
        return;
      end
      seen[u] = 1;
      for (int i = 0; i < degree[u]; i++) begin
        v = nbr[u][i] % NS;
        nd = m + nwt[u][i];
        if (!seen[v] && nd < best_d[v]) begin
          best_d[v] = nd;
          parent[v] = u;
        end
      end
    end
    push(wgpe_pkg::ST_NO_PATH, 0, 0, 1);
  endfunction

  // note an accepted command and work out its results
  function void note_command(logic [2:0] op, int unsigned a, int unsigned b, int unsigned w);
    case (op)
      wgpe_pkg::CMD_ADD_USER:
        if (next_id > MAXN) push(wgpe_pkg::ST_REJECT, 0, 0, 1);
        else push(wgpe_pkg::ST_OK, next_id++, 0, 1);
      wgpe_pkg::CMD_ADD_EDGE:
        if (a == b || !known(a) || !known(b) || linked(a, b) ||
            degree[a] >= MAXD || degree[b] >= MAXD)
          push(wgpe_pkg::ST_REJECT, 0, 0, 1);
        else begin
          nbr[a][degree[a]] = b;
          nwt[a][degree[a]] = w;
          degree[a]++;
          nbr[b][degree[b]] = a;
          nwt[b][degree[b]] = w;
          degree[b]++;
          push(wgpe_pkg::ST_OK, 0, 0, 1);
        end
      wgpe_pkg::CMD_REMOVE_EDGE: begin
        if (known(a)) unlink(a, b);
        if (known(b)) unlink(b, a);
        push(wgpe_pkg::ST_OK, 0, 0, 1);
      end
      wgpe_pkg::CMD_HOP_PATH, wgpe_pkg::CMD_WEIGHTED_PATH:
        if (a == b) push(wgpe_pkg::ST_OK, a, 0, 1);
        else if (op == wgpe_pkg::CMD_HOP_PATH) hop_search(a, b);
        else weight_search(a, b);
      default: push(wgpe_pkg::ST_REJECT, 0, 0, 1);
    endcase
  endfunction

  function void check_word(path_word_t got);
    path_word_t exp;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected word: st=%0d node=%0d dist=%0d last=%0b",
                                     got.status, got.node_id, got.path_distance, got.last);
      return;
    end
    exp = pending.pop_front();
    if (got.status !== exp.status || got.node_id !== exp.node_id ||
        got.path_distance !== exp.path_distance || got.last !== exp.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b (st/node/dist/last)",
                 exp.status, exp.node_id, exp.path_distance, exp.last,
                 got.status, got.node_id, got.path_distance, got.last);
    end
  endfunction
endclass

module tb;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  path_scoreboard board;
  int unsigned cycle_count;
  bit quiet;            // no idling on either side in the closing part
  bit timed_out;

  localparam int unsigned CYCLE_LIMIT = 20_000_000;

  weighted_graph_path_engine dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // cycle limit, guards against a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: random stall bursts, checks every accepted word
  initial begin
    path_word_t got;
    int stall;
    m_axis_tready = 0;
    @(posedge clk iff !rst);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 8);
        m_axis_tready <= 0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1;
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tuser;
        got.node_id = m_axis_tdata[6:0];
        got.path_distance = m_axis_tdata[38:7];
        got.last = m_axis_tlast;
        board.check_word(got);
      end
    end
  end

  // send one command word, now and then with a random gap before it
  task automatic send_command(logic [2:0] op, logic [6:0] a, logic [6:0] b, logic [15:0] w);
    int gap;
    if (!quiet && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 8);
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= op;
    s_axis_tdata <= {2'b0, w, b, a};
    do @(posedge clk); while (!s_axis_tready);
    board.note_command(op, a, b, w);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // a node id biased towards existing ones
  function automatic logic [6:0] pick_node();
    if ($urandom_range(0, 9) == 0) return 7'($urandom_range(0, 127));
    return 7'($urandom_range(1, board.next_id > 1 ? board.next_id - 1 : 1));
  endfunction

  initial begin
    logic [2:0] op;
    board = new();
    cycle_count = 0;
    quiet = 0;
    timed_out = 0;
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty graph, unknown nodes, same start and target
    send_command(wgpe_pkg::CMD_HOP_PATH, 7'd1, 7'd2, 16'd0);
    send_command(wgpe_pkg::CMD_WEIGHTED_PATH, 7'd127, 7'd127, 16'd0);
    send_command(wgpe_pkg::CMD_ADD_EDGE, 7'd1, 7'd2, 16'd5);
    repeat (4) send_command(wgpe_pkg::CMD_ADD_USER, 7'd0, 7'd0, 16'd0);
    send_command(wgpe_pkg::CMD_ADD_EDGE, 7'd1, 7'd1, 16'd3);       // self loop
    send_command(wgpe_pkg::CMD_ADD_EDGE, 7'd1, 7'd2, 16'hFFFF);
    send_command(wgpe_pkg::CMD_ADD_EDGE, 7'd2, 7'd1, 16'd1);       // already there
    send_command(wgpe_pkg::CMD_ADD_EDGE, 7'd2, 7'd3, 16'd0);
    send_command(wgpe_pkg::CMD_ADD_EDGE, 7'd1, 7'd3, 16'hFFFF);
    send_command(wgpe_pkg::CMD_ADD_EDGE, 7'd3, 7'd4, 16'd7);
    send_command(wgpe_pkg::CMD_ADD_EDGE, 7'd0, 7'd4, 16'd7);       // unknown node
    send_command(wgpe_pkg::CMD_HOP_PATH, 7'd1, 7'd4, 16'd0);
    send_command(wgpe_pkg::CMD_WEIGHTED_PATH, 7'd1, 7'd4, 16'd0);
    send_command(wgpe_pkg::CMD_WEIGHTED_PATH, 7'd4, 7'd1, 16'd0);
    send_command(wgpe_pkg::CMD_HOP_PATH, 7'd2, 7'd2, 16'd0);
    send_command(wgpe_pkg::CMD_REMOVE_EDGE, 7'd3, 7'd4, 16'd0);
    send_command(wgpe_pkg::CMD_REMOVE_EDGE, 7'd100, 7'd1, 16'd0);
    send_command(wgpe_pkg::CMD_WEIGHTED_PATH, 7'd1, 7'd4, 16'd0);  // unreachable
    send_command(wgpe_pkg::CMD_HOP_PATH, 7'd1, 7'd4, 16'd0);
    send_command(3'd5, 7'h7F, 7'h7F, 16'hFFFF);
    send_command(3'd7, 7'd0, 7'd0, 16'd0);
    // sender holds off until every result is in
    drain();

    // random: grow the graph mostly with well-formed edges and queries
    for (int n = 0; n < 50; n++) begin
      case ($urandom_range(0, 19))
        0, 1, 2:          op = wgpe_pkg::CMD_ADD_USER;
        3, 4, 5, 6, 7, 8: op = wgpe_pkg::CMD_ADD_EDGE;
        9, 10:            op = wgpe_pkg::CMD_REMOVE_EDGE;
        11, 12, 13:       op = wgpe_pkg::CMD_HOP_PATH;
        14, 15, 16, 17:   op = wgpe_pkg::CMD_WEIGHTED_PATH;
        default:          op = 3'($urandom_range(0, 7));
      endcase
      send_command(op, pick_node(), pick_node(),
                   $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 65535))
                                             : 16'($urandom_range(0, 20)));
    end
    // fill the id space to reach the users-full case
    while (board.next_id <= 63) send_command(wgpe_pkg::CMD_ADD_USER, 7'd0, 7'd0, 16'd0);
    send_command(wgpe_pkg::CMD_ADD_USER, 7'd0, 7'd0, 16'd0);
    // closing part without idling: a chain to the highest id, then wide queries
    quiet = 1;
    send_command(wgpe_pkg::CMD_ADD_EDGE, 7'd1, 7'd55, 16'd1);
    for (int i = 55; i < 63; i++)
      send_command(wgpe_pkg::CMD_ADD_EDGE, 7'(i), 7'(i + 1), 16'hFFFF);
    send_command(wgpe_pkg::CMD_WEIGHTED_PATH, 7'd1, 7'd63, 16'd0);
    send_command(wgpe_pkg::CMD_HOP_PATH, 7'd63, 7'd1, 16'd0);
    send_command(wgpe_pkg::CMD_WEIGHTED_PATH, 7'd63, 7'd2, 16'd0);

    drain();
    repeat (100) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
